// File: hw/rtl/rbrm_pkg.sv
// ----------------------------------------------------------------------------
// rbrm_pkg
// Shared types and constants for the receive ring buffer with reassembly map.
// ----------------------------------------------------------------------------
package rbrm_pkg;

    localparam int Depth = 1024;
    localparam int Aw    = $clog2(Depth);
    localparam int Sw    = Aw + 1;

    localparam logic [2:0] MODE_APPEND = 3'd0;
    localparam logic [2:0] MODE_PEEK   = 3'd1;
    localparam logic [2:0] MODE_POP    = 3'd2;
    localparam logic [2:0] MODE_RWRITE = 3'd3;
    localparam logic [2:0] MODE_MERGE  = 3'd4;
    localparam logic [2:0] MODE_COUNT  = 3'd5;
    localparam logic [2:0] MODE_WITHIN = 3'd6;
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  data_byte;
        logic [10:0] offset;
        logic [10:0] count;
        logic [9:0]  position;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic        done_res;
        logic [10:0] amount;
        logic [9:0]  slot;
        logic [9:0]  used_bytes;
        logic [9:0]  free_bytes;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture input item, compute sizes
        logic reduce;    // one subtraction of the offset reduction
        logic exec;      // work of the non-loop operations / set up loops
        logic step;      // one step of a loop: a merge clear or a mark-scan phase
        logic clr_step;  // one step of the clearing pass
        logic finish;    // build result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_loop;
        logic is_mod;
        logic mod_done;
        logic loop_done;
        logic clr_done;
    } t_sts;

endpackage

// File: hw/rtl/rbrm_ctrl.sv
// ----------------------------------------------------------------------------
// rbrm_ctrl
// Sequencer: accepts an item, drives the datapath through its steps, and
// holds the result until it is taken.
// ----------------------------------------------------------------------------
module rbrm_ctrl
    import rbrm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_clr_start
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_LOOP  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state, n_state;

    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_we;
    assign o_out_valid = (r_state == S_OUT);
    assign o_clr_start = i_cfg_we;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid && !i_cfg_we) begin
                    o_cmd.load = 1'b1;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (!i_sts.is_mod || i_sts.mod_done) n_state = S_EXEC;
                else o_cmd.reduce = 1'b1;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = i_sts.is_loop ? S_LOOP : S_FIN;
            end
            S_LOOP: begin
                if (i_sts.loop_done) n_state = S_FIN;
                else o_cmd.step = 1'b1;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_we) n_state = S_CLEAR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hw/rtl/rbrm_dp.sv
// ----------------------------------------------------------------------------
// rbrm_dp
// Datapath: pointers, size register, byte store, presence map and the
// iteration counters for modulo reduction, merge clears and mark scans.
// ----------------------------------------------------------------------------
module rbrm_dp
    import rbrm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [10:0] i_cfg_data,
    input  t_in_item    i_item,
    input  t_cmd        i_cmd,
    input  logic        i_clr_start,
    output t_sts        o_sts,
    output t_out_item   o_item
);

    logic [7:0]    r_store [Depth];
    logic          r_map   [Depth];

    logic [Sw-1:0] r_size;
    logic [Aw-1:0] r_rp, r_wp;
    t_in_item      r_it;
    logic [Sw-1:0] r_used, r_free;
    logic [Sw:0]   r_rem;       // offset being reduced modulo size
    logic [Aw-1:0] r_idx;
    logic [Sw-1:0] r_n;         // run / merge progress
    logic [Sw-1:0] r_lim;
    logic          r_wrapped;
    logic [Sw-1:0] r_first;     // run length before wrap
    logic [Aw-1:0] r_start;
    logic          r_done;
    logic [Sw-1:0] r_amount;
    logic [Aw-1:0] r_slot;
    logic          r_loop_done;
    logic [Aw-1:0] r_clr_idx;
    logic          r_clr_done;
    logic [7:0]    r_rd;
    logic          r_map_rd;
    logic          r_phase;
    t_out_item     r_out;

    logic [Sw-1:0] size_m1;
    logic [Sw-1:0] used_c;
    logic [Sw:0]   sum_c;
    logic [Sw-1:0] cfg_sat;
    logic [Sw:0]   wp_off;
    logic [Aw-1:0] wp_off_mod;
    logic [Sw:0]   rp_off;
    logic [Aw-1:0] rp_off_mod;
    logic [Sw:0]   step_nx;

    assign size_m1 = r_size - 1'b1;
    assign used_c  = (r_wp >= r_rp) ? Sw'(r_wp - r_rp) : Sw'(r_size + r_wp - r_rp);
    assign cfg_sat = (i_cfg_data < 11'd2) ? Sw'(2) :
                     (i_cfg_data > 11'(Depth)) ? Sw'(Depth) : Sw'(i_cfg_data);

    assign wp_off     = {2'b00, r_wp} + (Sw+1)'(r_it.offset);
    assign wp_off_mod = (wp_off >= {1'b0, r_size}) ? Aw'(wp_off - {1'b0, r_size})
                                                   : Aw'(wp_off);
    assign rp_off     = {2'b00, r_rp} + (Sw+1)'(r_it.offset);
    assign rp_off_mod = (rp_off >= {1'b0, r_size}) ? Aw'(rp_off - {1'b0, r_size})
                                                   : Aw'(rp_off);
    assign sum_c      = {2'b00, r_wp} + r_rem;
    assign step_nx    = {1'b0, r_n} + 1'b1;

    assign o_sts.is_loop   = (r_it.mode == MODE_MERGE) || (r_it.mode == MODE_COUNT);
    assign o_sts.is_mod    = (r_it.mode == MODE_COUNT) || (r_it.mode == MODE_WITHIN);
    assign o_sts.mod_done  = (r_rem < {1'b0, r_size});
    assign o_sts.loop_done = r_loop_done;
    assign o_sts.clr_done  = r_clr_done;
    assign o_item          = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr_start) begin
            r_rp        <= '0;
            r_wp        <= '0;
            r_clr_idx   <= '0;
            r_clr_done  <= 1'b0;
            r_size      <= i_rst_n ? cfg_sat : Sw'(Depth);
            r_loop_done <= 1'b0;
        end else begin
            r_map_rd <= r_map[r_idx];
            if (i_cmd.load) begin
                r_it   <= i_item;
                r_used <= used_c;
                r_free <= size_m1 - used_c;
                r_rem  <= (Sw+1)'(i_item.offset);
            end
            if (i_cmd.reduce) begin
                r_rem <= r_rem - {1'b0, r_size};
            end
            if (i_cmd.exec) begin
                r_done      <= 1'b0;
                r_amount    <= '0;
                r_slot      <= '0;
                r_loop_done <= 1'b0;
                r_n         <= '0;
                r_wrapped   <= 1'b0;
                r_phase     <= 1'b0;
                case (r_it.mode)
                    MODE_APPEND: begin
                        if (r_free != '0) begin
                            r_store[r_wp] <= r_it.data_byte;
                            r_wp   <= (Sw'(r_wp) + 1'b1 >= r_size) ? '0 : r_wp + 1'b1;
                            r_done <= 1'b1;
                        end
                    end
                    MODE_PEEK: begin
                        if (r_it.offset < r_used) begin
                            r_rd   <= r_store[rp_off_mod];
                            r_done <= 1'b1;
                        end
                    end
                    MODE_POP: begin
                        r_amount <= (r_it.count < r_used) ? r_it.count : r_used;
                        r_rp <= ((Sw+1)'(r_rp) + ((r_it.count < r_used) ?
                                 (Sw+1)'(r_it.count) : (Sw+1)'(r_used)) >= {1'b0, r_size})
                                ? Aw'(Sw'(r_rp) + ((r_it.count < r_used) ? r_it.count
                                      : r_used) - r_size)
                                : Aw'(Sw'(r_rp) + ((r_it.count < r_used) ? r_it.count
                                      : r_used));
                    end
                    MODE_RWRITE: begin
                        if (r_it.offset <= r_free) begin
                            r_slot <= wp_off_mod;
                            if (r_it.offset < r_free) begin
                                r_store[wp_off_mod] <= r_it.data_byte;
                                r_map[wp_off_mod]   <= 1'b1;
                                r_done <= 1'b1;
                            end
                        end
                    end
                    MODE_MERGE: begin
                        r_lim <= (r_it.count < r_free) ? r_it.count : r_free;
                        r_idx <= r_wp;
                        r_loop_done <= ((r_it.count < r_free) ? r_it.count : r_free) == '0;
                    end
                    MODE_COUNT: begin
                        r_start <= (sum_c >= {1'b0, r_size}) ? Aw'(sum_c - {1'b0, r_size})
                                                             : Aw'(sum_c);
                        r_idx   <= (sum_c >= {1'b0, r_size}) ? Aw'(sum_c - {1'b0, r_size})
                                                             : Aw'(sum_c);
                        r_lim   <= r_it.count;
                        r_loop_done <= (r_it.count == '0);
                    end
                    MODE_WITHIN: begin
                        if (Aw'(sum_c >= {1'b0, r_size} ? sum_c - {1'b0, r_size} : sum_c)
                                >= r_wp) begin
                            r_done <= (r_it.position >= r_wp) && (r_it.position <
                                Aw'(sum_c >= {1'b0, r_size} ? sum_c - {1'b0, r_size}
                                    : sum_c));
                        end else begin
                            r_done <= (r_it.position < Aw'(sum_c - {1'b0, r_size})) ||
                                ((r_it.position >= r_wp) && (Sw'(r_it.position) < r_size));
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.step && !r_loop_done && r_it.mode == MODE_MERGE) begin
                r_map[r_idx] <= 1'b0;
                r_idx <= (Sw'(r_idx) + 1'b1 >= r_size) ? '0 : r_idx + 1'b1;
                r_n   <= Sw'(step_nx);
                if (Sw'(step_nx) == r_lim) begin
                    r_loop_done <= 1'b1;
                    r_wp <= (Sw'(r_idx) + 1'b1 >= r_size) ? '0 : r_idx + 1'b1;
                end
            end
            if (i_cmd.step && !r_loop_done && r_it.mode == MODE_COUNT) begin
                r_phase <= !r_phase;
                if (r_phase) begin
                    if (!r_map_rd) begin
                        r_loop_done <= 1'b1;
                    end else begin
                        r_n <= Sw'(step_nx);
                        if (Sw'(step_nx) == r_lim) begin
                            r_loop_done <= 1'b1;
                        end else if (!r_wrapped) begin
                            if (Sw'(r_idx) + 1'b1 >= r_size) begin
                                if (r_start == '0) r_loop_done <= 1'b1;
                                r_wrapped <= 1'b1;
                                r_first   <= Sw'(step_nx);
                                r_idx     <= '0;
                            end else begin
                                r_idx <= r_idx + 1'b1;
                            end
                        end else begin
                            if (Sw'(step_nx) - r_first >= Sw'(r_start)) r_loop_done <= 1'b1;
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
            end
            if (i_cmd.clr_step) begin
                r_map[r_clr_idx] <= 1'b0;
                r_clr_idx  <= r_clr_idx + 1'b1;
                if (r_clr_idx == Aw'(Depth - 1)) r_clr_done <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_out.read_byte  <= (r_it.mode == MODE_PEEK && r_done) ? r_rd : 8'd0;
                r_out.done_res   <= r_done;
                r_out.amount     <= (r_it.mode == MODE_MERGE || r_it.mode == MODE_COUNT)
                                    ? r_n : r_amount;
                r_out.slot       <= r_slot;
                r_out.used_bytes <= Aw'(used_c);
                r_out.free_bytes <= Aw'(size_m1 - used_c);
            end
        end
    end

endmodule

// File: hw/rtl/ring_buffer_with_reassembly_map.sv
// ----------------------------------------------------------------------------
// ring_buffer_with_reassembly_map
// Receive ring buffer with out-of-order reassembly presence map.
// ----------------------------------------------------------------------------
// Sequence: an accepted item passes through the reduce, execute, finish and output states.
// Count and within tests first subtract the size from the offset until it falls below the size.
// Merge adds a loop that clears one map bit per step; mark count scans slots in read and check phases.
// Only one item is in the block at a time; the next item
// is accepted the cycle after the result is taken.
// Reset and every size write hold off items for a presence map clearing pass.
module ring_buffer_with_reassembly_map
    import rbrm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item
);

    t_cmd cmd;
    t_sts sts;
    logic clr_start;

    rbrm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_clr_start (clr_start)
    );

    rbrm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_in_item),
        .i_cmd       (cmd),
        .i_clr_start (clr_start),
        .o_sts       (sts),
        .o_item      (o_out_item)
    );

endmodule

// File: bench/rbrm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbrm_checker
// Watches both item channels and the size register port of the ring buffer,
// keeps its own copy of the ring, the presence map and the pointers, predicts
// each result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module rbrm_checker
    import rbrm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [10:0] i_cfg_data,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_errors,
    output int        o_pending
);

    logic [7:0] ring_bytes [Depth];
    logic       marks [Depth];
    int         rd_ptr;
    int         wr_ptr;
    int         ring_len;
    t_out_item  results_due [$];

    function automatic int held();
        return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : ring_len + wr_ptr - rd_ptr;
    endfunction

    function automatic int advance(int base, int add);
        int s;
        s = base + add;
        if (s >= ring_len) begin
            s -= ring_len;
        end
        return s;
    endfunction

    function automatic int mark_run(int start, int limit);
        int n;
        n = 0;
        while (n < limit && start + n < ring_len && marks[start + n]) begin
            n++;
        end
        return n;
    endfunction

    function automatic t_out_item apply_item(t_in_item it);
        t_out_item r;
        int fr, us, lim, st, fin;
        r  = '0;
        us = held();
        fr = ring_len - 1 - us;
        case (it.mode)
            MODE_APPEND: begin
                if (fr > 0) begin
                    ring_bytes[wr_ptr] = it.data_byte;
                    wr_ptr = advance(wr_ptr, 1);
                    r.done_res = 1'b1;
                end
            end
            MODE_PEEK: begin
                if (int'(it.offset) < us) begin
                    r.read_byte = ring_bytes[advance(rd_ptr, it.offset)];
                    r.done_res  = 1'b1;
                end
            end
            MODE_POP: begin
                r.amount = 11'((int'(it.count) < us) ? int'(it.count) : us);
                rd_ptr = advance(rd_ptr, r.amount);
            end
            MODE_RWRITE: begin
                if (int'(it.offset) <= fr) begin
                    st = advance(wr_ptr, it.offset);
                    r.slot = 10'(st);
                    if (int'(it.offset) < fr) begin
                        ring_bytes[st] = it.data_byte;
                        marks[st] = 1'b1;
                        r.done_res = 1'b1;
                    end
                end
            end
            MODE_MERGE: begin
                r.amount = 11'((int'(it.count) < fr) ? int'(it.count) : fr);
                for (int i = 0; i < r.amount; i++) begin
                    marks[wr_ptr] = 1'b0;
                    wr_ptr = advance(wr_ptr, 1);
                end
            end
            MODE_COUNT: begin
                st  = (wr_ptr + it.offset) % ring_len;
                fin = mark_run(st, it.count);
                if (fin < it.count && fin >= ring_len - st) begin
                    lim = it.count - fin;
                    if (lim > st) begin
                        lim = st;
                    end
                    fin += mark_run(0, lim);
                end
                r.amount = 11'(fin);
            end
            MODE_WITHIN: begin
                st  = wr_ptr;
                fin = (st + it.offset) % ring_len;
                if (fin >= st) begin
                    r.done_res = (it.position >= st && it.position < fin);
                end else begin
                    r.done_res = (it.position < fin
                                  || (it.position >= st && it.position < ring_len));
                end
            end
            default: begin
            end
        endcase
        r.used_bytes = 10'(held());
        r.free_bytes = 10'(ring_len - 1 - held());
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
        o_errors++;
    endtask

    assign o_pending = results_due.size();

    initial begin
        o_errors = 0;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            rd_ptr   = 0;
            wr_ptr   = 0;
            ring_len = Depth;
            for (int i = 0; i < Depth; i++) begin
                marks[i] = 1'b0;
            end
            results_due.delete();
        end else begin
            if (i_cfg_we) begin
                ring_len = (i_cfg_data < 2) ? 2 : (i_cfg_data > Depth) ? Depth : i_cfg_data;
                rd_ptr = 0;
                wr_ptr = 0;
                for (int i = 0; i < Depth; i++) begin
                    marks[i] = 1'b0;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("unexpected item", 1, 0);
                end else begin
                    want = results_due.pop_front();
                    if (i_out_item.read_byte != want.read_byte)
                        report_mismatch("read_byte", i_out_item.read_byte, want.read_byte);
                    if (i_out_item.done_res != want.done_res)
                        report_mismatch("done_res", i_out_item.done_res, want.done_res);
                    if (i_out_item.amount != want.amount)
                        report_mismatch("amount", i_out_item.amount, want.amount);
                    if (i_out_item.slot != want.slot)
                        report_mismatch("slot", i_out_item.slot, want.slot);
                    if (i_out_item.used_bytes != want.used_bytes)
                        report_mismatch("used_bytes", i_out_item.used_bytes,
                                        want.used_bytes);
                    if (i_out_item.free_bytes != want.free_bytes)
                        report_mismatch("free_bytes", i_out_item.free_bytes,
                                        want.free_bytes);
                end
            end
            if (i_in_valid && i_in_ready) begin
                results_due.push_back(apply_item(i_in_item));
            end
        end
    end

endmodule

// File: bench/tb_ring_buffer_with_reassembly_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ring_buffer_with_reassembly_map
// Drives the ring buffer with directed and random operation items under
// several ring sizes, with random idling on both channels, and reports the
// verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_ring_buffer_with_reassembly_map;
    import rbrm_pkg::*;

    localparam int StallLimit = 20000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    logic [10:0] cfg_data = '0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;
    int        errors;
    int        pending;
    int        quiet_cycles = 0;
    bit        calm = 1'b0;
    int        held_est = 0;
    int        cur_size = Depth;

    always #5 i_clk = ~i_clk;

    ring_buffer_with_reassembly_map u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    rbrm_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .i_in_ready (in_ready),
        .i_in_item  (in_item),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_out_item (out_item),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always @(negedge i_clk) begin
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 24);
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= StallLimit) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Valid stays high after acceptance until the caller either presents the
    // next item or idles; it is dropped on the same falling edge.
    task automatic send_item(t_in_item it);
        while (!calm && $urandom_range(99) < 24) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        while (!in_ready) begin
            @(negedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic send_op(logic [2:0] md, int db, int off, int cnt, int pos);
        t_in_item it;
        it.mode      = md;
        it.data_byte = 8'(db);
        it.offset    = 11'(off);
        it.count     = 11'(cnt);
        it.position  = 10'(pos);
        send_item(it);
    endtask

    task automatic set_size(int value);
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (3000) @(negedge i_clk);
        cfg_data <= 11'(value);
        cfg_we   <= 1'b1;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        cur_size = (value < 2) ? 2 : (value > Depth) ? Depth : value;
        held_est = 0;
    endtask

    // Peeks mostly stay inside the appended data and those past it are refused, so no
    // unwritten entry is read; random merges have a count of zero and clear no slot.
    task automatic random_op();
        int sel, off, cap;
        sel = $urandom_range(99);
        cap = cur_size - 1;
        if (sel < 30) begin
            send_op(MODE_APPEND, $urandom, $urandom, $urandom, $urandom);
            if (held_est < cap) held_est++;
        end else if (sel < 45) begin
            off = (held_est > 0) ? $urandom_range(held_est - 1) : 0;
            if ($urandom_range(9) == 0) off = $urandom_range(2047);
            if (held_est == 0 && off < 1) off = 0;
            if (off >= held_est && held_est > 0 && $urandom_range(1)) off = held_est;
            send_op(MODE_PEEK, $urandom, (held_est == 0 && off == 0) ? 0 : off,
                    $urandom, $urandom);
        end else if (sel < 58) begin
            off = $urandom_range(($urandom_range(7) == 0) ? 2047 : 8);
            send_op(MODE_POP, $urandom, $urandom, off, $urandom);
            held_est -= (off < held_est) ? off : held_est;
        end else if (sel < 72) begin
            off = ($urandom_range(7) == 0) ? $urandom_range(2047)
                                           : $urandom_range(cap - held_est);
            send_op(MODE_RWRITE, $urandom, off, $urandom, $urandom);
        end else if (sel < 80) begin
            // Append first, then send a merge whose count of zero clears no slot.
            send_op(MODE_APPEND, $urandom, 0, 0, 0);
            if (held_est < cap) held_est++;
            send_op(MODE_MERGE, $urandom, $urandom, 0, $urandom);
        end else if (sel < 90) begin
            send_op(MODE_COUNT, $urandom,
                    ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(8),
                    ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(12),
                    $urandom);
        end else if (sel < 97) begin
            send_op(MODE_WITHIN, $urandom, $urandom_range(2047), $urandom,
                    $urandom_range(1023));
        end else begin
            send_op(MODE_UNUSED, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (1100) @(negedge i_clk);

        // Directed: every operation and the edge cases at the reset size.
        send_op(MODE_PEEK, 8'h00, 0, 0, 0);
        send_op(MODE_POP, 8'h00, 0, 2047, 0);
        send_op(MODE_MERGE, 8'h00, 0, 0, 0);
        send_op(MODE_APPEND, 8'hFF, 2047, 2047, 1023);
        send_op(MODE_APPEND, 8'h00, 0, 0, 0);
        send_op(MODE_PEEK, 8'h00, 1, 0, 0);
        send_op(MODE_PEEK, 8'h00, 2, 0, 0);
        send_op(MODE_RWRITE, 8'hA5, 1, 0, 0);
        send_op(MODE_RWRITE, 8'h5A, 0, 0, 0);
        send_op(MODE_RWRITE, 8'h11, 1021, 0, 0);
        send_op(MODE_RWRITE, 8'h11, 1022, 0, 0);
        send_op(MODE_RWRITE, 8'h11, 2047, 0, 0);
        send_op(MODE_COUNT, 8'h00, 0, 2047, 0);
        send_op(MODE_COUNT, 8'h00, 2047, 5, 0);
        send_op(MODE_WITHIN, 8'h00, 1024, 0, 2);
        send_op(MODE_WITHIN, 8'h00, 2047, 0, 1023);
        send_op(MODE_WITHIN, 8'h00, 5, 0, 4);
        send_op(MODE_UNUSED, 8'h00, 0, 0, 0);
        send_op(MODE_MERGE, 8'h00, 0, 2, 0);
        send_op(MODE_POP, 8'h00, 0, 2047, 0);

        // Small ring: fill past full, wrapped mark count.
        set_size(0);
        send_op(MODE_RWRITE, 8'h33, 0, 0, 0);
        send_op(MODE_APPEND, 8'h44, 0, 0, 0);
        send_op(MODE_APPEND, 8'h55, 0, 0, 0);
        send_op(MODE_PEEK, 8'h00, 0, 0, 0);
        send_op(MODE_POP, 8'h00, 0, 1, 0);
        send_op(MODE_COUNT, 8'h00, 1, 2, 0);

        begin : random_phases
            int sizes [5] = '{2047, 5, 17, 300, 2};
            for (int p = 0; p < 5; p++) begin
                set_size(sizes[p]);
                calm = (p == 2);
                for (int n = 0; n < 175; n++) begin
                    random_op();
                end
                calm = 1'b0;
            end
        end

        in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (3000) @(negedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/rbrm_pkg.sv
hw/rtl/rbrm_ctrl.sv
hw/rtl/rbrm_dp.sv
hw/rtl/ring_buffer_with_reassembly_map.sv
bench/rbrm_checker.sv
bench/tb_ring_buffer_with_reassembly_map.sv
